// ===== sv/hhm_pkg.sv =====
`default_nettype none

package hhm_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_BEAT = 2'd1;
    localparam logic [1:0] ACT_SCAN = 2'd2;

    // health codes
    localparam logic [1:0] HEALTH_OK        = 2'd0;
    localparam logic [1:0] HEALTH_WARNING   = 2'd1;
    localparam logic [1:0] HEALTH_ERROR     = 2'd2;
    localparam logic [1:0] HEALTH_RESTARTED = 2'd3;

    // register indexes and reset values
    localparam logic REG_SILENCE = 1'b0;
    localparam logic REG_JITTER  = 1'b1;
    localparam logic [15:0] SILENCE_RESET = 16'd1500;
    localparam logic [15:0] JITTER_RESET  = 16'd50;

    // lowest valid sender id
    localparam logic [7:0] ID_MIN = 8'h01;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] node_id;
        logic [7:0] sequence_number;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] device_index;
        logic [1:0] health;
        logic [8:0] delivered_total;
        logic [8:0] dropped_total;
        logic       last_of_run;
    } out_beat_t;

    // command passed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] node_id;
        logic [7:0] seq;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/heartbeat_health_monitor.sv =====
`default_nettype none

// Heartbeat health monitor. Input beats are ticks, heartbeats and timeout scans; the front end
// takes one beat per cycle while the two-entry command queue has room, dropping heartbeats from
// unknown senders and the unused action code; the back-end sequencer works one command at a
// time. A heartbeat passes the beat, record and emit states, plus an evict state once its
// window is full, since the evicted outcome is read from the single-port history memory before
// its slot is rewritten; a scan records and emits each timed-out device, and an emit waits for
// the result register to drain. The history memory needs no clearing pass: entries are only
// read after they were written. Registers: silence_timeout at 0x0, jitter_limit at 0x4.
module heartbeat_health_monitor
    import hhm_pkg::*;
#(
    parameter int DEVICE_COUNT   = 4,
    parameter int HISTORY_WINDOW = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data
);

    logic [15:0] silence_reg, silence_next;
    logic [15:0] jitter_reg, jitter_next;
    logic        cfg_wr;
    logic        q_full, q_push, q_pop, q_valid;
    cmd_t        push_cmd, pop_cmd;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        silence_next = silence_reg;
        jitter_next  = jitter_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_SILENCE: silence_next = pwdata[15:0];
                REG_JITTER:  jitter_next  = pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_reg <= SILENCE_RESET;
            jitter_reg  <= JITTER_RESET;
        end else begin
            silence_reg <= silence_next;
            jitter_reg  <= jitter_next;
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_SILENCE: prdata = {16'd0, silence_reg};
            REG_JITTER:  prdata = {16'd0, jitter_reg};
            default:     prdata = 32'd0;
        endcase
    end

    hhm_front #(
        .DEVICE_COUNT(DEVICE_COUNT)
    ) u_front (
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    hhm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_cmd  (pop_cmd)
    );

    hhm_back #(
        .DEVICE_COUNT  (DEVICE_COUNT),
        .HISTORY_WINDOW(HISTORY_WINDOW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .silence_timeout(silence_reg),
        .jitter_limit   (jitter_reg),
        .q_valid        (q_valid),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/hhm_front.sv =====
`default_nettype none

module hhm_front
    import hhm_pkg::*;
#(
    parameter int DEVICE_COUNT = 4
) (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic known_id;
    logic keep;

    // sender must be one of the configured devices
    assign known_id = (s_data.node_id >= ID_MIN) &&
                      (s_data.node_id <= 8'(DEVICE_COUNT));

    // heartbeats from unknown senders and the unused action code are taken and dropped
    always_comb begin
        case (s_data.action)
            ACT_TICK: keep = 1'b1;
            ACT_SCAN: keep = 1'b1;
            ACT_BEAT: keep = known_id;
            default:  keep = 1'b0;
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

    assign q_cmd.op      = s_data.action;
    assign q_cmd.node_id = s_data.node_id;
    assign q_cmd.seq     = s_data.sequence_number;

endmodule

`default_nettype wire

// ===== sv/hhm_queue.sv =====
`default_nettype none

module hhm_queue
    import hhm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hhm_back.sv =====
`default_nettype none

module hhm_back
    import hhm_pkg::*;
#(
    parameter int DEVICE_COUNT   = 4,
    parameter int HISTORY_WINDOW = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] silence_timeout,
    input  wire logic [15:0] jitter_limit,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data
);

    localparam int DEV_W     = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int SLOT_W    = $clog2(HISTORY_WINDOW);
    localparam int CNT_W     = $clog2(HISTORY_WINDOW + 1);
    localparam int MEM_DEPTH = DEVICE_COUNT * HISTORY_WINDOW;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [DEV_W-1:0]  LAST_DEV  = DEV_W'(DEVICE_COUNT - 1);
    localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(HISTORY_WINDOW);
    localparam logic [CNT_W:0]    WIN_WIDE  = (CNT_W + 1)'(HISTORY_WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_WINDOW - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BEAT  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_REC   = 3'd3;
    localparam logic [2:0] ST_EVICT = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    is_beat_reg, is_beat_next;
    logic [7:0]              seq_reg, seq_next;
    logic [DEV_W-1:0]        cur_reg, cur_next;
    logic [DEVICE_COUNT-1:0] mask_reg, mask_next;
    logic                    rec_del_reg, rec_del_next;
    logic [15:0]             time_reg, time_next;

    logic [15:0]       seen_reg [DEVICE_COUNT];
    logic [15:0]       seen_next [DEVICE_COUNT];
    logic [15:0]       gap_reg [DEVICE_COUNT];
    logic [15:0]       gap_next [DEVICE_COUNT];
    logic [7:0]        pseq_reg [DEVICE_COUNT];
    logic [7:0]        pseq_next [DEVICE_COUNT];
    logic [1:0]        health_reg [DEVICE_COUNT];
    logic [1:0]        health_next [DEVICE_COUNT];
    logic [CNT_W-1:0]  del_reg [DEVICE_COUNT];
    logic [CNT_W-1:0]  del_next [DEVICE_COUNT];
    logic [CNT_W-1:0]  drop_reg [DEVICE_COUNT];
    logic [CNT_W-1:0]  drop_next [DEVICE_COUNT];
    logic [SLOT_W-1:0] head_reg [DEVICE_COUNT];
    logic [SLOT_W-1:0] head_next [DEVICE_COUNT];
    logic [CNT_W-1:0]  fill_reg [DEVICE_COUNT];
    logic [CNT_W-1:0]  fill_next [DEVICE_COUNT];

    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;

    logic                    hist_mem [MEM_DEPTH];
    logic                    rd_bit_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_addr;

    logic [DEVICE_COUNT-1:0] timeout_vec;
    logic [DEVICE_COUNT-1:0] above_vec;
    logic [15:0]             gap;
    logic signed [17:0]      jit_diff;
    logic                    jit_hit;
    logic [1:0]              beat_health;
    logic [CNT_W:0]          slot_wide;
    logic [SLOT_W-1:0]       slot;
    logic                    win_full;
    logic                    out_free;
    logic                    last_scan;
    logic [CNT_W-1:0]        del_adj, drop_adj;

    // silence test of every device against the timeout
    always_comb begin
        for (int i = 0; i < DEVICE_COUNT; i++) begin
            timeout_vec[i] = (16'(time_reg - seen_reg[i]) > silence_timeout);
            above_vec[i]   = (DEV_W'(i) > cur_reg);
        end
    end

    assign last_scan = ~|(mask_reg & above_vec);

    // heartbeat classification for the current device
    assign gap      = 16'(time_reg - seen_reg[cur_reg]);
    assign jit_diff = $signed({2'b00, gap}) - $signed({2'b00, gap_reg[cur_reg]});
    assign jit_hit  = (gap_reg[cur_reg] != 16'd0) &&
                      (jit_diff > $signed({2'b00, jitter_limit}));

    always_comb begin
        if (seq_reg == 8'd0 && pseq_reg[cur_reg] != 8'd0) begin
            beat_health = HEALTH_RESTARTED;
        end else if (jit_hit) begin
            beat_health = HEALTH_WARNING;
        end else if (seq_reg == pseq_reg[cur_reg]) begin
            beat_health = HEALTH_WARNING;
        end else if (seq_reg < pseq_reg[cur_reg] && seq_reg != 8'd0) begin
            beat_health = HEALTH_WARNING;
        end else begin
            beat_health = HEALTH_OK;
        end
    end

    // history slot: oldest entry when full, next free entry otherwise
    assign win_full  = (fill_reg[cur_reg] >= WIN_CNT);
    assign slot_wide = (CNT_W + 1)'(head_reg[cur_reg]) + (CNT_W + 1)'(fill_reg[cur_reg]);
    always_comb begin
        if (win_full) begin
            slot = head_reg[cur_reg];
        end else if (slot_wide >= WIN_WIDE) begin
            slot = SLOT_W'(slot_wide - WIN_WIDE);
        end else begin
            slot = SLOT_W'(slot_wide);
        end
    end
    assign mem_addr = ADDR_W'(ADDR_W'(cur_reg) * ADDR_W'(HISTORY_WINDOW)) + ADDR_W'(slot);

    // counts after evicting the oldest outcome and adding the new one
    always_comb begin
        del_adj  = del_reg[cur_reg];
        drop_adj = drop_reg[cur_reg];
        if (rd_bit_reg) begin
            if (del_adj != '0) del_adj = del_adj - CNT_W'(1);
        end else begin
            if (drop_adj != '0) drop_adj = drop_adj - CNT_W'(1);
        end
        if (rec_del_reg) begin
            del_adj = del_adj + CNT_W'(1);
        end else begin
            drop_adj = drop_adj + CNT_W'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        is_beat_next = is_beat_reg;
        seq_next     = seq_reg;
        cur_next     = cur_reg;
        mask_next    = mask_reg;
        rec_del_next = rec_del_reg;
        time_next    = time_reg;
        seen_next    = seen_reg;
        gap_next     = gap_reg;
        pseq_next    = pseq_reg;
        health_next  = health_reg;
        del_next     = del_reg;
        drop_next    = drop_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    case (q_cmd.op)
                        ACT_TICK: begin
                            time_next = time_reg + 16'd1;
                        end
                        ACT_BEAT: begin
                            cur_next     = DEV_W'(q_cmd.node_id - ID_MIN);
                            seq_next     = q_cmd.seq;
                            is_beat_next = 1'b1;
                            state_next   = ST_BEAT;
                        end
                        ACT_SCAN: begin
                            cur_next     = '0;
                            mask_next    = timeout_vec;
                            is_beat_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BEAT: begin
                health_next[cur_reg] = beat_health;
                seen_next[cur_reg]   = time_reg;
                gap_next[cur_reg]    = gap;
                pseq_next[cur_reg]   = seq_reg;
                rec_del_next         = 1'b1;
                state_next           = ST_REC;
            end
            ST_SCAN: begin
                if (mask_reg[cur_reg]) begin
                    health_next[cur_reg] = HEALTH_ERROR;
                    rec_del_next         = 1'b0;
                    state_next           = ST_REC;
                end else if (cur_reg == LAST_DEV) begin
                    state_next = ST_IDLE;
                end else begin
                    cur_next = cur_reg + DEV_W'(1);
                end
            end
            ST_REC: begin
                if (win_full) begin
                    mem_re     = 1'b1;
                    state_next = ST_EVICT;
                end else begin
                    mem_we             = 1'b1;
                    fill_next[cur_reg] = fill_reg[cur_reg] + CNT_W'(1);
                    if (rec_del_reg) begin
                        del_next[cur_reg] = del_reg[cur_reg] + CNT_W'(1);
                    end else begin
                        drop_next[cur_reg] = drop_reg[cur_reg] + CNT_W'(1);
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EVICT: begin
                mem_we             = 1'b1;
                del_next[cur_reg]  = del_adj;
                drop_next[cur_reg] = drop_adj;
                head_next[cur_reg] = (head_reg[cur_reg] == LAST_SLOT) ? '0 :
                                     head_reg[cur_reg] + SLOT_W'(1);
                state_next         = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.device_index    = 2'(cur_reg);
                    m_data_next.health          = health_reg[cur_reg];
                    m_data_next.delivered_total = 9'(del_reg[cur_reg]);
                    m_data_next.dropped_total   = 9'(drop_reg[cur_reg]);
                    m_data_next.last_of_run     = is_beat_reg ? 1'b1 : last_scan;
                    if (is_beat_reg || cur_reg == LAST_DEV) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = cur_reg + DEV_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and per-device state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            is_beat_reg <= 1'b0;
            cur_reg     <= '0;
            mask_reg    <= '0;
            rec_del_reg <= 1'b0;
            time_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < DEVICE_COUNT; i++) begin
                seen_reg[i]   <= 16'd0;
                gap_reg[i]    <= 16'd0;
                pseq_reg[i]   <= 8'd0;
                health_reg[i] <= HEALTH_ERROR;
                del_reg[i]    <= '0;
                drop_reg[i]   <= '0;
                head_reg[i]   <= '0;
                fill_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            is_beat_reg <= is_beat_next;
            cur_reg     <= cur_next;
            mask_reg    <= mask_next;
            rec_del_reg <= rec_del_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
            seen_reg    <= seen_next;
            gap_reg     <= gap_next;
            pseq_reg    <= pseq_next;
            health_reg  <= health_next;
            del_reg     <= del_next;
            drop_reg    <= drop_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        seq_reg    <= seq_next;
        m_data_reg <= m_data_next;
    end

    // outcome history memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_addr] <= rec_del_reg;
        end
        if (mem_re) begin
            rd_bit_reg <= hist_mem[mem_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/hhm_checker.sv =====
`default_nettype none

module hhm_checker
    import hhm_pkg::*;
#(
    parameter int DEVICE_COUNT   = 4,
    parameter int HISTORY_WINDOW = 256
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed before it was taken");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // only a scan gives more than one result, and scans report errors
    a_run_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_run |-> m_data.health == HEALTH_ERROR)
        else $error("non-final result of a run is not an error");

    // window counts never exceed the window
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (HISTORY_WINDOW <= 255) |->
        (({1'b0, m_data.delivered_total} + {1'b0, m_data.dropped_total}) <=
         10'(HISTORY_WINDOW)))
        else $error("window counts exceed the history window");

    // reported device is a configured one
    a_dev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (DEVICE_COUNT <= 4) |-> (int'(m_data.device_index) < DEVICE_COUNT))
        else $error("result for a device outside the configured range");

endmodule

bind heartbeat_health_monitor hhm_checker #(
    .DEVICE_COUNT  (DEVICE_COUNT),
    .HISTORY_WINDOW(HISTORY_WINDOW)
) u_hhm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
